FILE: src/rectangle_raster_canvas_unit_defines.svh
// assertion macros for the rectangle raster canvas unit
`ifndef RECTANGLE_RASTER_CANVAS_UNIT_DEFINES_SVH
`define RECTANGLE_RASTER_CANVAS_UNIT_DEFINES_SVH

// same-cycle implication
`define RRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrc assertion failed");

// next-cycle implication
`define RRC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrc assertion failed");

`endif

FILE: src/rrc_pkg.sv
// shared constants, types and helpers for the rectangle raster canvas
`default_nettype none

package rrc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W = 19;
  localparam int DIM_W   = 9;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] RESET_BYTE   = 8'd32;
  localparam logic [BYTE_W-1:0] KIND_FILLED  = 8'd82;
  localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'd114;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_BACKGROUND = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  kind;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } rect_t;

  // index bits for a dimension of n entries
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // bits for a dimension count up to the maximum, at least the register width
  function automatic int dim_bits(input int w, input int h);
    int b;
    b = DIM_W;
    if ($clog2(w + 1) > b) b = $clog2(w + 1);
    if ($clog2(h + 1) > b) b = $clog2(h + 1);
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: src/rrc_if.sv
// request, result and configuration channel interfaces
`default_nettype none

interface rrc_req_if;
  import rrc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [BYTE_W-1:0]         rect_kind;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_width;
  logic signed [COORD_W-1:0] rect_height;
  logic [BYTE_W-1:0]         paint_char;
  logic [BYTE_W-1:0]         read_row;
  logic [BYTE_W-1:0]         read_col;
  modport source (output valid, operation, rect_kind, rect_left, rect_top, rect_width,
                  rect_height, paint_char, read_row, read_col, input ready);
  modport sink   (input valid, operation, rect_kind, rect_left, rect_top, rect_width,
                  rect_height, paint_char, read_row, read_col, output ready);
endinterface

interface rrc_res_if;
  import rrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel;
  logic              status;
  modport source (output valid, pixel, status, input ready);
  modport sink   (input valid, pixel, status, output ready);
endinterface

interface rrc_cfg_if;
  import rrc_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       reg_index;
  logic [DIM_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: src/rrc_geom.sv
// rectangle bounds registers and per-cell paint test
`default_nettype none

module rrc_geom #(
  parameter int MAX_WIDTH  = rrc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rrc_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      load,
  input  wire rrc_pkg::rect_t                            rect,
  input  wire logic [rrc_pkg::idx_bits(MAX_HEIGHT)-1:0]  row,
  input  wire logic [rrc_pkg::idx_bits(MAX_WIDTH)-1:0]   col,
  output logic                                           hit
);
  import rrc_pkg::*;

  localparam int RB   = idx_bits(MAX_HEIGHT);
  localparam int CB   = idx_bits(MAX_WIDTH);
  localparam int MAXB = (RB > CB) ? RB : CB;
  localparam int PW   = (MAXB + FRAC_BITS > 20) ? MAXB + FRAC_BITS + 2 : 22;
  localparam logic signed [PW-1:0] ONE =
    {{(PW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [PW-1:0] x1, x2, x1p, x2m;
  logic signed [PW-1:0] y1, y2, y1p, y2m;
  logic signed [PW-1:0] x1_in, y1_in, x2_in, y2_in;
  logic                 filled;
  logic signed [PW-1:0] cx, ly;
  logic                 in_x, in_y, border;

  assign x1_in = PW'($signed(rect.left));
  assign y1_in = PW'($signed(rect.top));
  assign x2_in = x1_in + PW'($signed(rect.width));
  assign y2_in = y1_in + PW'($signed(rect.height));

  always_ff @(posedge clk) begin
    if (load) begin
      x1     <= x1_in;
      x2     <= x2_in;
      x1p    <= x1_in + ONE;
      x2m    <= x2_in - ONE;
      y1     <= y1_in;
      y2     <= y2_in;
      y1p    <= y1_in + ONE;
      y2m    <= y2_in - ONE;
      filled <= (rect.kind == KIND_FILLED);
    end
  end

  assign cx = {{(PW-CB-FRAC_BITS){1'b0}}, col, {FRAC_BITS{1'b0}}};
  assign ly = {{(PW-RB-FRAC_BITS){1'b0}}, row, {FRAC_BITS{1'b0}}};

  assign in_x   = (cx >= x1) && (cx <= x2);
  assign in_y   = (ly >= y1) && (ly <= y2);
  assign border = (cx < x1p) || (cx > x2m) || (ly < y1p) || (ly > y2m);
  assign hit    = in_x && in_y && (filled || border);

endmodule

`default_nettype wire

FILE: src/rectangle_raster_canvas_unit.sv
// top level of the rectangle raster canvas: canvas memory, sequencer and channels
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------
//  req     | in  | valid/ready  | operation, rect fields, paint_char, read pos
//  res     | out | valid/ready  | pixel, status
//  cfg     | in  | valid/ready  | reg_index, wdata (always ready)
//
// after reset a clearing pass writes 2**(RB+CB) cells (65536 at default size)
// before the first request is taken; a clear request takes the same sweep
// a draw walks the canvas in use one cell per cycle; a rejected draw or an empty canvas skips the walk
// a read goes through the registered canvas memory read port, then ST_READ and ST_DONE
// the result register lets a new request in while the last result waits;
// a finished request holds until that register is free

`default_nettype none

module rectangle_raster_canvas_unit #(
  parameter int MAX_WIDTH  = rrc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rrc_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rrc_req_if.sink   req,
  rrc_res_if.source res,
  rrc_cfg_if.sink   cfg
);
  import rrc_pkg::*;

  `include "rectangle_raster_canvas_unit_defines.svh"

  localparam int RB    = idx_bits(MAX_HEIGHT);
  localparam int CB    = idx_bits(MAX_WIDTH);
  localparam int AW    = RB + CB;
  localparam int DEPTH = 2 ** AW;
  localparam int DB    = dim_bits(MAX_WIDTH, MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  state_t            state;
  logic [RB-1:0]     row;
  logic [CB-1:0]     col;
  logic [DIM_W-1:0]  canvas_width;
  logic [DIM_W-1:0]  canvas_height;
  logic [BYTE_W-1:0] background;
  logic [BYTE_W-1:0] pend_pixel;
  logic              pend_status;
  logic              res_valid;
  logic [BYTE_W-1:0] res_pixel;
  logic              res_status;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     raddr;

  logic [DB-1:0]     w_used, h_used;
  logic              req_acc, res_free;
  logic              rd_bad, draw_bad, empty;
  logic              col_last, row_last, sweep_last;
  logic              geom_hit;
  rect_t             rect;

  // dimensions in use, saturated at the maximum
  assign w_used = (DB'(canvas_width) > DB'(MAX_WIDTH)) ? DB'(MAX_WIDTH) : DB'(canvas_width);
  assign h_used = (DB'(canvas_height) > DB'(MAX_HEIGHT)) ? DB'(MAX_HEIGHT)
                                                         : DB'(canvas_height);

  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign res_free  = !res_valid || res.ready;

  assign rd_bad   = (DB'(req.read_row) >= h_used) || (DB'(req.read_col) >= w_used);
  assign draw_bad = (req.rect_width <= 0) || (req.rect_height <= 0) ||
                    ((req.rect_kind != KIND_FILLED) && (req.rect_kind != KIND_OUTLINE));
  assign empty    = (w_used == '0) || (h_used == '0);

  assign col_last   = ((DB'(col) + DB'(1)) == w_used);
  assign row_last   = ((DB'(row) + DB'(1)) == h_used);
  assign sweep_last = &{row, col};

  assign rect = '{kind:   req.rect_kind,
                  left:   req.rect_left,
                  top:    req.rect_top,
                  width:  req.rect_width,
                  height: req.rect_height};

  rrc_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_geom (
    .clk  (clk),
    .load (req_acc && (req.operation == OP_DRAW)),
    .rect (rect),
    .row  (row),
    .col  (col),
    .hit  (geom_hit)
  );

  // canvas memory: one write port, one registered read port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = background;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BYTE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = background;
      end
      ST_SCAN: begin
        mem_we    = geom_hit;
        mem_wdata = pend_pixel;
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = background;
      end
    endcase
  end

  assign raddr = {RB'(req.read_row), CB'(req.read_col)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{row, col}] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= DIM_W'(256);
      canvas_height <= DIM_W'(256);
      background    <= RESET_BYTE;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_WIDTH:      canvas_width  <= cfg.wdata;
        REG_HEIGHT:     canvas_height <= cfg.wdata;
        REG_BACKGROUND: background    <= cfg.wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      row       <= '0;
      col       <= '0;
      res_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          {row, col} <= {row, col} + AW'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_acc) begin
            row <= '0;
            col <= '0;
            case (req.operation)
              OP_CLEAR: begin
                pend_pixel  <= '0;
                pend_status <= 1'b0;
                state       <= ST_CLEAR;
              end
              OP_DRAW: begin
                pend_status <= draw_bad;
                if (draw_bad || empty) begin
                  pend_pixel <= '0;
                  state      <= ST_DONE;
                end else begin
                  pend_pixel <= req.paint_char;
                  state      <= ST_SCAN;
                end
              end
              OP_READ: begin
                pend_pixel  <= '0;
                pend_status <= rd_bad;
                if (rd_bad) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_READ;
                end
              end
              default: begin
                pend_pixel  <= '0;
                pend_status <= 1'b1;
                state       <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          {row, col} <= {row, col} + AW'(1);
          if (sweep_last) begin
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              pend_pixel <= '0;
              state      <= ST_DONE;
            end else begin
              row <= row + RB'(1);
            end
          end else begin
            col <= col + CB'(1);
          end
        end
        ST_READ: begin
          pend_pixel <= rdata;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free) begin
            res_pixel  <= pend_pixel;
            res_status <= pend_status;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid  = res_valid;
  assign res.pixel  = res_pixel;
  assign res.status = res_status;

  `RRC_ASSERT_IMP(a_write_busy, clk, rst, mem_we, (state == ST_INIT) || (state == ST_CLEAR) || (state == ST_SCAN))
  `RRC_ASSERT_NXT(a_read_issue, clk, rst, req_acc && (req.operation == OP_READ) && !rd_bad, state == ST_READ)
  `RRC_ASSERT_NXT(a_result_load, clk, rst, (state == ST_DONE) && !res_valid, res_valid && (state == ST_IDLE))
  `RRC_ASSERT_IMP(a_scan_in_range, clk, rst, state == ST_SCAN, (DB'(col) < w_used) && (DB'(row) < h_used))

endmodule

`default_nettype wire

FILE: tb/sv/rectangle_raster_canvas_checker.sv
`timescale 1ns / 100ps
// checker for the rectangle raster canvas: shadow canvas, result prediction and comparison
module rectangle_raster_canvas_checker (
  input  logic clk,
  input  logic rst,
  rrc_req_if   req,
  rrc_res_if   res,
  rrc_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding
);
  import rrc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              status;
  } cell_result_t;

  logic [BYTE_W-1:0] shadow_canvas [MAX_HEIGHT_DEF][MAX_WIDTH_DEF];
  logic [DIM_W-1:0]  cols_reg;
  logic [DIM_W-1:0]  rows_reg;
  logic [BYTE_W-1:0] bg_reg;
  cell_result_t      pending_results [$];
  int                fails = 0;

  function automatic cell_result_t apply_request(
    input logic [1:0]                op,
    input logic [BYTE_W-1:0]         kind,
    input logic signed [COORD_W-1:0] left,
    input logic signed [COORD_W-1:0] top,
    input logic signed [COORD_W-1:0] wid,
    input logic signed [COORD_W-1:0] hgt,
    input logic [BYTE_W-1:0]         paint,
    input logic [BYTE_W-1:0]         row,
    input logic [BYTE_W-1:0]         col
  );
    cell_result_t r;
    longint       one, x1, y1, x2, y2, cx, ly;
    int           ncols, nrows;
    bit           on_border;
    r = '0;
    ncols = (cols_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cols_reg);
    nrows = (rows_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(rows_reg);
    one = longint'(1) << FRAC_BITS_DEF;
    case (op)
      OP_CLEAR: begin
        for (int l = 0; l < MAX_HEIGHT_DEF; l++)
          for (int c = 0; c < MAX_WIDTH_DEF; c++)
            shadow_canvas[l][c] = bg_reg;
      end
      OP_DRAW: begin
        x1 = longint'(left);
        y1 = longint'(top);
        if (wid <= 0 || hgt <= 0 || (kind != KIND_FILLED && kind != KIND_OUTLINE)) begin
          r.status = 1'b1;
        end else begin
          x2 = x1 + longint'(wid);
          y2 = y1 + longint'(hgt);
          for (int l = 0; l < nrows; l++) begin
            ly = longint'(l) * one;
            if (ly >= y1 && ly <= y2) begin
              for (int c = 0; c < ncols; c++) begin
                cx = longint'(c) * one;
                if (cx >= x1 && cx <= x2) begin
                  on_border = (cx - x1 < one) || (x2 - cx < one) ||
                              (ly - y1 < one) || (y2 - ly < one);
                  if (kind == KIND_FILLED || on_border)
                    shadow_canvas[l][c] = paint;
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        if (int'(row) >= nrows || int'(col) >= ncols)
          r.status = 1'b1;
        else
          r.pixel = shadow_canvas[row][col];
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      for (int l = 0; l < MAX_HEIGHT_DEF; l++)
        for (int c = 0; c < MAX_WIDTH_DEF; c++)
          shadow_canvas[l][c] = RESET_BYTE;
      cols_reg = DIM_W'(MAX_WIDTH_DEF);
      rows_reg = DIM_W'(MAX_HEIGHT_DEF);
      bg_reg   = RESET_BYTE;
      pending_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_WIDTH:      cols_reg = cfg.wdata;
          REG_HEIGHT:     rows_reg = cfg.wdata;
          REG_BACKGROUND: bg_reg   = cfg.wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: pixel %0d, status %0d",
                 res.pixel, res.status);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (res.pixel !== want.pixel) begin
            $error("pixel: expected %0d, got %0d", want.pixel, res.pixel);
            fails++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(apply_request(req.operation, req.rect_kind,
          req.rect_left, req.rect_top, req.rect_width, req.rect_height,
          req.paint_char, req.read_row, req.read_col));
    end
    fail_count  <= fails;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/rectangle_raster_canvas_unit_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the rectangle raster canvas unit
module rectangle_raster_canvas_unit_test;
  import rrc_pkg::*;

  localparam int         Q           = 1 << FRAC_BITS_DEF;
  localparam int         CYCLE_LIMIT = 10_000_000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]                op;
    logic [BYTE_W-1:0]         kind;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] wid;
    logic signed [COORD_W-1:0] hgt;
    logic [BYTE_W-1:0]         paint;
    logic [BYTE_W-1:0]         row;
    logic [BYTE_W-1:0]         col;
  } canvas_req_t;

  logic        clk  = 1'b0;
  logic        rst;
  logic        calm = 1'b0;
  int          fail_count;
  int          outstanding;
  int unsigned cycles = 0;
  int          cur_cols = MAX_WIDTH_DEF;
  int          cur_rows = MAX_HEIGHT_DEF;

  rrc_req_if req ();
  rrc_res_if res ();
  rrc_cfg_if cfg ();

  rectangle_raster_canvas_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  rectangle_raster_canvas_checker canvas_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) res.ready <= calm || ($urandom_range(99) >= 36);

  function automatic canvas_req_t draw_item(input logic [BYTE_W-1:0] kind, input int left,
                                            input int top, input int wid, input int hgt,
                                            input logic [BYTE_W-1:0] paint);
    canvas_req_t it;
    it       = '0;
    it.op    = OP_DRAW;
    it.kind  = kind;
    it.left  = COORD_W'(left);
    it.top   = COORD_W'(top);
    it.wid   = COORD_W'(wid);
    it.hgt   = COORD_W'(hgt);
    it.paint = paint;
    return it;
  endfunction

  function automatic canvas_req_t read_item(input int row, input int col);
    canvas_req_t it;
    it     = '0;
    it.op  = OP_READ;
    it.row = BYTE_W'(row);
    it.col = BYTE_W'(col);
    return it;
  endfunction

  function automatic canvas_req_t op_item(input logic [1:0] op);
    canvas_req_t it;
    it    = '0;
    it.op = op;
    return it;
  endfunction

  function automatic canvas_req_t random_item();
    canvas_req_t       it;
    int                pick, cols_used, rows_used, span;
    logic [BYTE_W-1:0] k;
    cols_used = (cur_cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_cols;
    rows_used = (cur_rows > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cur_rows;
    pick = $urandom_range(99);
    it = op_item(OP_READ);
    it.row = BYTE_W'($urandom);
    it.col = BYTE_W'($urandom);
    if (pick < 2) begin
      it = op_item(OP_CLEAR);
    end else if (pick < 5) begin
      it = op_item(OP_UNUSED);
    end else if (pick < 13) begin
      // raw draw over the whole field range
      case ($urandom_range(2))
        0:       k = KIND_FILLED;
        1:       k = KIND_OUTLINE;
        default: k = BYTE_W'($urandom);
      endcase
      it = draw_item(k, 0, 0, 0, 0, BYTE_W'($urandom));
      it.left = COORD_W'($urandom);
      it.top  = COORD_W'($urandom);
      it.wid  = COORD_W'($urandom);
      it.hgt  = COORD_W'($urandom);
    end else if (pick < 19) begin
      // rejected draw
      it = draw_item($urandom_range(1) ? KIND_FILLED : KIND_OUTLINE,
                     $urandom_range(0, 4 * Q), $urandom_range(0, 4 * Q),
                     $urandom_range(1, 4 * Q), $urandom_range(1, 4 * Q),
                     BYTE_W'($urandom));
      case ($urandom_range(2))
        0: it.wid = COORD_W'(-int'($urandom_range(0, 262144)));
        1: it.hgt = COORD_W'(-int'($urandom_range(0, 262144)));
        default: begin
          do k = BYTE_W'($urandom); while (k == KIND_FILLED || k == KIND_OUTLINE);
          it.kind = k;
        end
      endcase
    end else if (pick < 57) begin
      span = $urandom_range(1) ? 4 * Q : (cols_used + 2) * Q;
      it = draw_item($urandom_range(1) ? KIND_FILLED : KIND_OUTLINE,
                     int'($urandom_range(0, (cols_used + 2) * Q)) - 2 * Q,
                     int'($urandom_range(0, (rows_used + 2) * Q)) - 2 * Q,
                     $urandom_range(1, span),
                     $urandom_range(1, $urandom_range(1) ? 4 * Q : (rows_used + 2) * Q),
                     BYTE_W'($urandom));
    end else if (pick >= 67) begin
      it = read_item($urandom_range(0, (rows_used > 0) ? rows_used - 1 : 0),
                     $urandom_range(0, (cols_used > 0) ? cols_used - 1 : 0));
    end
    return it;
  endfunction

  task automatic send_req(input canvas_req_t it);
    while (!calm && $urandom_range(99) < 36) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.operation   <= it.op;
    req.rect_kind   <= it.kind;
    req.rect_left   <= it.left;
    req.rect_top    <= it.top;
    req.rect_width  <= it.wid;
    req.rect_height <= it.hgt;
    req.paint_char  <= it.paint;
    req.read_row    <= it.row;
    req.read_col    <= it.col;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= DIM_W'(value);
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_canvas(input int cols, input int rows, input int bg);
    wait_results();
    write_reg(REG_WIDTH, cols);
    write_reg(REG_HEIGHT, rows);
    write_reg(REG_BACKGROUND, bg);
    cfg.valid <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_req(random_item());
  endtask

  initial begin
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.operation   <= OP_CLEAR;
    req.rect_kind   <= '0;
    req.rect_left   <= '0;
    req.rect_top    <= '0;
    req.rect_width  <= '0;
    req.rect_height <= '0;
    req.paint_char  <= '0;
    req.read_row    <= '0;
    req.read_col    <= '0;
    cfg.valid       <= 1'b0;
    cfg.reg_index   <= REG_WIDTH;
    cfg.wdata       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings, full canvas
    send_req(read_item(0, 0));
    send_req(draw_item(KIND_OUTLINE, 250 * Q, 250 * Q, 1408, 5 * Q, 8'h6F));
    send_req(read_item(255, 255));
    send_req(read_item(252, 252));

    set_canvas(10, 8, 8'h2E);
    send_req(op_item(OP_CLEAR));
    send_req(draw_item(KIND_FILLED, -262144, -262144, 262143, 262143, 8'h00));
    send_req(draw_item(KIND_FILLED, 0, 0, 262143, 262143, 8'hFF));
    send_req(draw_item(KIND_OUTLINE, 320, 128, 6 * Q, 1216, 8'h42));
    send_req(draw_item(KIND_FILLED, 640, Q, 128, 1, 8'h78));
    send_req(draw_item(KIND_FILLED, 0, 0, 0, Q, 8'h41));
    send_req(draw_item(KIND_OUTLINE, 0, 0, Q, -1, 8'h41));
    send_req(draw_item(8'h00, 0, 0, Q, Q, 8'h41));
    send_req(read_item(0, 0));
    send_req(read_item(7, 9));
    send_req(read_item(1, 3));
    send_req(read_item(8, 0));
    send_req(read_item(0, 10));
    send_req(op_item(OP_UNUSED));

    // empty canvas, oversized rows
    set_canvas(0, 300, 8'hFF);
    send_req(draw_item(KIND_FILLED, 0, 0, Q, Q, 8'h51));
    send_req(read_item(0, 0));
    send_req(op_item(OP_CLEAR));

    set_canvas(511, 1, 8'h00);
    send_req(draw_item(KIND_OUTLINE, 0, 0, 255 * Q, Q, 8'h65));
    send_req(read_item(0, 255));
    send_req(read_item(1, 0));

    set_canvas(1, 511, 8'hA5);
    send_req(draw_item(KIND_FILLED, 0, 200 * Q, Q, 55 * Q, 8'h7A));
    send_req(read_item(255, 0));

    // random phases over several canvas shapes
    set_canvas($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 255));
    random_phase(15);
    set_canvas(256, $urandom_range(1, 2), $urandom_range(0, 255));
    random_phase(15);
    set_canvas($urandom_range(1, 2), 256, $urandom_range(0, 255));
    calm <= 1'b1;
    random_phase(15);
    set_canvas($urandom_range(257, 511), $urandom_range(1, 3), $urandom_range(0, 255));
    calm <= 1'b0;
    random_phase(15);
    set_canvas($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 255));
    random_phase(15);

    wait_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: rectangle_raster_canvas_unit.f
+incdir+src
src/rrc_pkg.sv
src/rrc_if.sv
src/rrc_geom.sv
src/rectangle_raster_canvas_unit.sv
tb/sv/rectangle_raster_canvas_checker.sv
tb/sv/rectangle_raster_canvas_unit_test.sv
